// ===== src/m4i_pkg.sv =====
// ----------------------------------------------------------------------------
// m4i_pkg: shared types and tables for the 4x4 matrix inverse unit
// Element, minor and determinant widths, stream payloads, the 2x2 minor
// operand table and the cofactor term table.
// ----------------------------------------------------------------------------
package m4i_pkg;

    // element and intermediate widths
    localparam int ElemW     = 16;               // Q8.8 element
    localparam int MinorW    = 2 * ElemW + 1;    // exact 2x2 sub-determinant
    localparam int DetW      = 2 * MinorW;       // exact determinant, Q32.32
    localparam int DmagW     = DetW - 1;         // determinant magnitude
    localparam int CofW      = 50;               // exact cofactor, Q24.24
    localparam int MagW      = CofW - 1;         // cofactor magnitude
    localparam int FracShift = 24;               // scale of the numerator
    localparam int NumW      = MagW + FracShift; // dividend width
    localparam int QuoW      = 33;               // kept low quotient bits
    localparam int OutW      = 32;               // Q16.16 result
    localparam int CntW      = 7;                // holds NumW - 1
    localparam int DetShift  = 16;               // Q32.32 to Q16.16
    localparam int DqW       = DetW - DetShift;  // shifted determinant

    typedef logic signed [ElemW-1:0]  elem_t;
    typedef logic signed [MinorW-1:0] minor_t;
    typedef logic signed [DetW-1:0]   det_t;
    typedef logic signed [OutW-1:0]   fix_t;

    // one matrix row per transfer
    typedef struct packed {
        elem_t elem_c0;
        elem_t elem_c1;
        elem_t elem_c2;
        elem_t elem_c3;
    } row_item_t;

    // one inverse row per transfer
    typedef struct packed {
        fix_t       inv_c0;
        fix_t       inv_c1;
        fix_t       inv_c2;
        fix_t       inv_c3;
        logic [1:0] out_row;
        logic       last_row;
        logic       singular;
        fix_t       det_value;
    } inv_item_t;

    // command from the row sequencer to every lane
    typedef struct packed {
        logic       start;
        logic [1:0] row;
        logic       sing;
        logic       dneg;
    } lane_cmd_t;

    // operand indexes of one minor a*b - c*d, row-major element numbers
    typedef struct packed {
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic [3:0] d;
    } minor_ops_t;

    // one cofactor term: element column in the lane's row, minor index
    typedef struct packed {
        logic [1:0] col;
        logic [2:0] xi;
    } cof_term_t;

    // minors 0..5 come from rows 0,1, minors 6..11 the same pattern on rows 2,3
    function automatic minor_ops_t minor_ops(input logic [3:0] j);
        minor_ops_t ops;
        logic       low;
        logic [2:0] p;
        low = (j < 4'd6);
        p   = low ? j[2:0] : 3'(j - 4'd6);
        unique case (p)
            3'd0:    ops = '{a: 4'd0, b: 4'd5, c: 4'd4, d: 4'd1};
            3'd1:    ops = '{a: 4'd0, b: 4'd6, c: 4'd4, d: 4'd2};
            3'd2:    ops = '{a: 4'd0, b: 4'd7, c: 4'd4, d: 4'd3};
            3'd3:    ops = '{a: 4'd1, b: 4'd6, c: 4'd5, d: 4'd2};
            3'd4:    ops = '{a: 4'd1, b: 4'd7, c: 4'd5, d: 4'd3};
            3'd5:    ops = '{a: 4'd2, b: 4'd7, c: 4'd6, d: 4'd3};
            default: ops = '{a: 4'd0, b: 4'd0, c: 4'd0, d: 4'd0};
        endcase
        if (!low)
        begin
            ops.a = ops.a + 4'd8;
            ops.b = ops.b + 4'd8;
            ops.c = ops.c + 4'd8;
            ops.d = ops.d + 4'd8;
        end
        return ops;
    endfunction

    // term t of a cofactor in inverse row r: skips column r
    function automatic cof_term_t cof_term(input logic [1:0] r, input logic [1:0] t);
        cof_term_t ct;
        ct.col = (t >= r) ? 2'(t + 2'd1) : t;
        unique case ({r, t})
            4'h0:    ct.xi = 3'd5;
            4'h1:    ct.xi = 3'd4;
            4'h2:    ct.xi = 3'd3;
            4'h4:    ct.xi = 3'd5;
            4'h5:    ct.xi = 3'd2;
            4'h6:    ct.xi = 3'd1;
            4'h8:    ct.xi = 3'd4;
            4'h9:    ct.xi = 3'd2;
            4'hA:    ct.xi = 3'd0;
            4'hC:    ct.xi = 3'd3;
            4'hD:    ct.xi = 3'd1;
            4'hE:    ct.xi = 3'd0;
            default: ct.xi = 3'd0;
        endcase
        return ct;
    endfunction

endpackage

// ===== src/m4i_stream_if.sv =====
// ----------------------------------------------------------------------------
// m4i_stream_if: valid/ready stream channel
// One payload moves per transfer, when valid and ready are both high.
// ----------------------------------------------------------------------------
interface m4i_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ===== src/matrix4_inverse_determinant_unit.sv =====
// ----------------------------------------------------------------------------
// matrix4_inverse_determinant_unit: streaming 4x4 matrix inverse
// Loads a Q8.8 matrix one row per transfer and returns four Q16.16 inverse
// rows with the determinant, by cofactors over the exact determinant.
// ----------------------------------------------------------------------------
// Rows are taken one per cycle while the block is loading. After the fourth
// row, a shared element multiplier forms the twelve 2x2 minors, and a
// second multiplier accumulates their products into the determinant; no
// row is accepted until the last inverse row is registered. Four lanes,
// one per inverse column, then work on one inverse row at a time: a
// three-term cofactor accumulation, then a bit-serial division that takes
// most of the time. Each finished row waits in an output register, so the
// lanes start the next row while it is held.
// A zero determinant returns zero elements with singular set.
module matrix4_inverse_determinant_unit
    import m4i_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    m4i_stream_if.sink   mat,
    m4i_stream_if.source inv
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_MINOR = 2'd1;
    localparam logic [1:0] ST_ROWS  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] slot_reg;
    logic [1:0] row_idx_reg;
    logic       minor_start_reg;
    logic       lane_start_reg;
    logic       out_valid_reg;
    inv_item_t  out_reg;
    elem_t      mat_reg [16];

    minor_t           s_val [6];
    minor_t           c_val [6];
    det_t             det;
    logic             minor_done;
    logic             sing;
    logic             dneg;
    logic [DmagW-1:0] dmag;
    logic [DqW-1:0]   dq;
    fix_t             det_sat;
    lane_cmd_t        lane_cmd;
    logic [3:0]       lane_done;
    fix_t             lane_val [4];
    elem_t            lane_row [4][4];
    logic             in_xfer;
    logic             all_done;
    logic             out_free;
    logic             row_load;
    row_item_t        in_item;

    assign in_item   = mat.payload;
    assign mat.ready = (state_reg == ST_LOAD);
    assign in_xfer   = mat.valid && mat.ready;

    // matrix row storage
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mat_reg[{slot_reg, 2'd0}] <= in_item.elem_c0;
            mat_reg[{slot_reg, 2'd1}] <= in_item.elem_c1;
            mat_reg[{slot_reg, 2'd2}] <= in_item.elem_c2;
            mat_reg[{slot_reg, 2'd3}] <= in_item.elem_c3;
        end
    end

    m4i_minor u_minor (
        .clk   (clk),
        .rst_n (rst_n),
        .start (minor_start_reg),
        .mat   (mat_reg),
        .s_out (s_val),
        .c_out (c_val),
        .det   (det),
        .done  (minor_done)
    );

    // determinant sign, magnitude and Q16.16 form
    always_comb
    begin
        sing = (det == '0);
        dneg = det[DetW-1];
        dmag = dneg ? DmagW'(-det) : det[DmagW-1:0];
        dq   = det[DetW-1:DetShift];
        if ((&dq[DqW-1:OutW-1]) || !(|dq[DqW-1:OutW-1]))
            det_sat = dq[OutW-1:0];
        else if (dq[DqW-1])
            det_sat = {1'b1, {(OutW-1){1'b0}}};
        else
            det_sat = {1'b0, {(OutW-1){1'b1}}};
    end

    assign lane_cmd = '{start: lane_start_reg, row: row_idx_reg, sing: sing, dneg: dneg};

    // one lane per inverse column
    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        localparam int MRow = k ^ 1;
        for (genvar j = 0; j < 4; j++)
        begin : g_elem
            assign lane_row[k][j] = mat_reg[MRow * 4 + j];
        end
        if (k < 2)
        begin : g_cset
            m4i_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (lane_cmd),
                .odd_lane (1'(k % 2)),
                .m_row    (lane_row[k]),
                .x_set    (c_val),
                .dmag     (dmag),
                .done     (lane_done[k]),
                .value    (lane_val[k])
            );
        end
        else
        begin : g_sset
            m4i_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (lane_cmd),
                .odd_lane (1'(k % 2)),
                .m_row    (lane_row[k]),
                .x_set    (s_val),
                .dmag     (dmag),
                .done     (lane_done[k]),
                .value    (lane_val[k])
            );
        end
    end

    // merge handshake
    assign all_done = (state_reg == ST_ROWS) && (&lane_done) && !lane_start_reg;
    assign out_free = !out_valid_reg || inv.ready;
    assign row_load = all_done && out_free;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            slot_reg        <= '0;
            row_idx_reg     <= '0;
            minor_start_reg <= 1'b0;
            lane_start_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            minor_start_reg <= 1'b0;
            lane_start_reg  <= 1'b0;
            if (row_load)
                out_valid_reg <= 1'b1;
            else if (inv.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_xfer)
                    begin
                        slot_reg <= slot_reg + 2'd1;
                        if (slot_reg == 2'd3)
                        begin
                            state_reg       <= ST_MINOR;
                            minor_start_reg <= 1'b1;
                        end
                    end
                end
                ST_MINOR:
                begin
                    if (minor_done)
                    begin
                        state_reg      <= ST_ROWS;
                        row_idx_reg    <= '0;
                        lane_start_reg <= 1'b1;
                    end
                end
                ST_ROWS:
                begin
                    if (row_load)
                    begin
                        if (row_idx_reg == 2'd3)
                        begin
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            row_idx_reg    <= row_idx_reg + 2'd1;
                            lane_start_reg <= 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // output row register
    always_ff @(posedge clk)
    begin
        if (row_load)
        begin
            out_reg.inv_c0    <= lane_val[0];
            out_reg.inv_c1    <= lane_val[1];
            out_reg.inv_c2    <= lane_val[2];
            out_reg.inv_c3    <= lane_val[3];
            out_reg.out_row   <= row_idx_reg;
            out_reg.last_row  <= (row_idx_reg == 2'd3);
            out_reg.singular  <= sing;
            out_reg.det_value <= sing ? '0 : det_sat;
        end
    end

    assign inv.valid   = out_valid_reg;
    assign inv.payload = out_reg;

endmodule

// ===== src/m4i_minor.sv =====
// ----------------------------------------------------------------------------
// m4i_minor: 2x2 minors and determinant
// A shared element multiplier forms the twelve exact minors; a second one
// accumulates the six minor products into the exact determinant.
// ----------------------------------------------------------------------------
module m4i_minor
    import m4i_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  elem_t  mat [16],
    output minor_t s_out [6],
    output minor_t c_out [6],
    output det_t   det,
    output logic   done
);

    localparam logic [4:0] MinorSteps = 5'd24;
    localparam logic [4:0] LastStep   = 5'd29;

    logic                    busy_reg;
    logic                    done_reg;
    logic [4:0]              step_reg;
    logic signed [2*ElemW-1:0] prod_reg;
    minor_t                  s_reg [6];
    minor_t                  c_reg [6];
    det_t                    det_reg;

    minor_ops_t              ops;
    logic                    phase;
    elem_t                   mul_a;
    elem_t                   mul_b;
    logic signed [2*ElemW-1:0] prod_small;
    minor_t                  minor_val;
    logic [3:0]              mj;
    logic [3:0]              cj;
    logic [4:0]              dstep;
    logic [2:0]              di;
    logic [2:0]              ci;
    det_t                    det_prod;
    logic                    det_sub;

    // operand select for the shared element multiplier
    always_comb
    begin
        mj         = step_reg[4:1];
        cj         = mj - 4'd6;
        ops        = minor_ops(mj);
        phase      = step_reg[0];
        mul_a      = phase ? mat[ops.c] : mat[ops.a];
        mul_b      = phase ? mat[ops.d] : mat[ops.b];
        prod_small = mul_a * mul_b;
        minor_val  = MinorW'(prod_reg) - MinorW'(prod_small);
    end

    // determinant term: s[i] * c[5-i], negated for i = 1 and 4
    always_comb
    begin
        dstep    = step_reg - MinorSteps;
        di       = dstep[2:0];
        ci       = 3'd5 - di;
        det_prod = s_reg[di] * c_reg[ci];
        det_sub  = (di == 3'd1) || (di == 3'd4);
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == LastStep);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 5'd1;
                if (step_reg == LastStep)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // minor and determinant datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            det_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg < MinorSteps)
            begin
                if (!phase)
                begin
                    prod_reg <= prod_small;
                end
                else if (mj < 4'd6)
                begin
                    s_reg[mj[2:0]] <= minor_val;
                end
                else
                begin
                    c_reg[cj[2:0]] <= minor_val;
                end
            end
            else
            begin
                det_reg <= det_sub ? det_reg - det_prod : det_reg + det_prod;
            end
        end
    end

    assign s_out = s_reg;
    assign c_out = c_reg;
    assign det   = det_reg;
    assign done  = done_reg;

endmodule

// ===== src/m4i_lane.sv =====
// ----------------------------------------------------------------------------
// m4i_lane: one inverse column
// Accumulates a three-term cofactor, then divides its scaled magnitude by
// the determinant magnitude one quotient bit per cycle and saturates.
// ----------------------------------------------------------------------------
module m4i_lane
    import m4i_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lane_cmd_t        cmd,
    input  logic             odd_lane,
    input  elem_t            m_row [4],
    input  minor_t           x_set [6],
    input  logic [DmagW-1:0] dmag,
    output logic             done,
    output fix_t             value
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MAC  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [CntW-1:0] LastMac = CntW'(2);
    localparam logic [CntW-1:0] LastDiv = CntW'(NumW - 1);

    logic [1:0]            phase_reg;
    logic [CntW-1:0]       cnt_reg;
    logic [1:0]            row_reg;
    logic                  sing_reg;
    logic                  dneg_reg;
    logic                  neg_reg;
    logic signed [CofW-1:0] acc_reg;
    logic [NumW-1:0]       num_reg;
    logic [DmagW-1:0]      rem_reg;
    logic [QuoW-1:0]       q_reg;
    logic                  ovf_reg;

    cof_term_t             term;
    logic signed [CofW-1:0] prod;
    logic                  term_neg;
    logic signed [CofW-1:0] acc_sum;
    logic signed [CofW-1:0] acc_abs;
    logic [DmagW:0]        sh;
    logic [DmagW:0]        diff;
    logic                  ge;
    fix_t                  sat_val;

    // cofactor term multiply-accumulate
    always_comb
    begin
        term     = cof_term(row_reg, cnt_reg[1:0]);
        prod     = m_row[term.col] * x_set[term.xi];
        term_neg = cnt_reg[0] ^ row_reg[0] ^ odd_lane;
        acc_sum  = term_neg ? acc_reg - prod : acc_reg + prod;
        acc_abs  = acc_sum[CofW-1] ? -acc_sum : acc_sum;
    end

    // restoring divide step
    always_comb
    begin
        sh   = {rem_reg, num_reg[NumW-1]};
        diff = sh - {1'b0, dmag};
        ge   = (sh >= {1'b0, dmag});
    end

    // saturate the signed quotient to Q16.16
    always_comb
    begin
        if (!neg_reg)
        begin
            if (ovf_reg || q_reg[QuoW-1] || q_reg[OutW-1])
                sat_val = {1'b0, {(OutW-1){1'b1}}};
            else
                sat_val = q_reg[OutW-1:0];
        end
        else
        begin
            if (ovf_reg || q_reg[QuoW-1] || (q_reg[OutW-1] && (|q_reg[OutW-2:0])))
                sat_val = {1'b1, {(OutW-1){1'b0}}};
            else
                sat_val = -q_reg[OutW-1:0];
        end
    end

    // phase control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else if (cmd.start)
        begin
            phase_reg <= PH_MAC;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_MAC:
                begin
                    cnt_reg <= (cnt_reg == LastMac) ? '0 : cnt_reg + CntW'(1);
                    if (cnt_reg == LastMac)
                        phase_reg <= PH_DIV;
                end
                PH_DIV:
                begin
                    cnt_reg <= cnt_reg + CntW'(1);
                    if (cnt_reg == LastDiv)
                        phase_reg <= PH_DONE;
                end
                PH_IDLE, PH_DONE:
                begin
                    cnt_reg <= cnt_reg;
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    // cofactor and quotient datapath
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            row_reg  <= cmd.row;
            sing_reg <= cmd.sing;
            dneg_reg <= cmd.dneg;
            acc_reg  <= '0;
        end
        else if (phase_reg == PH_MAC)
        begin
            acc_reg <= acc_sum;
            if (cnt_reg == LastMac)
            begin
                neg_reg <= acc_sum[CofW-1] ^ dneg_reg;
                num_reg <= {acc_abs[MagW-1:0], {FracShift{1'b0}}};
                rem_reg <= '0;
                q_reg   <= '0;
                ovf_reg <= 1'b0;
            end
        end
        else if (phase_reg == PH_DIV)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? diff[DmagW-1:0] : sh[DmagW-1:0];
            q_reg   <= {q_reg[QuoW-2:0], ge};
            ovf_reg <= ovf_reg | q_reg[QuoW-1];
        end
    end

    assign done  = (phase_reg == PH_DONE);
    assign value = sing_reg ? '0 : sat_val;

endmodule

// ===== src/m4i_checker.sv =====
// ----------------------------------------------------------------------------
// m4i_checker: port-level checks for the matrix inverse unit
// Watches both channels and the inverse row sequence; bound to the top level.
// ----------------------------------------------------------------------------
module m4i_checker
    import m4i_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      mat_valid,
    input logic      mat_ready,
    input logic      inv_valid,
    input logic      inv_ready,
    input inv_item_t inv_item
);

    logic [1:0] exp_row_reg;

    // expected row index of the next inverse transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_row_reg <= '0;
        else if (inv_valid && inv_ready)
            exp_row_reg <= exp_row_reg + 2'd1;
    end

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && !inv_ready |=> inv_valid && $stable(inv_item))
        else $error("inverse row changed while stalled");

    // rows come out in order 0..3
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid |-> inv_item.out_row == exp_row_reg)
        else $error("inverse row out of sequence");

    // last flag marks row 3 only
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid |-> inv_item.last_row == (inv_item.out_row == 2'd3))
        else $error("last_row does not match out_row");

    // singular matrix gives zeros
    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv_item.singular |->
            inv_item.inv_c0 == '0 && inv_item.inv_c1 == '0 &&
            inv_item.inv_c2 == '0 && inv_item.inv_c3 == '0 &&
            inv_item.det_value == '0)
        else $error("singular row with nonzero data");

    // rows are taken only once the pending result is the final one
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        mat_valid && mat_ready && inv_valid |-> inv_item.last_row)
        else $error("row accepted while inverse rows still pending");

endmodule

bind matrix4_inverse_determinant_unit m4i_checker u_m4i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat_valid (mat.valid),
    .mat_ready (mat.ready),
    .inv_valid (inv.valid),
    .inv_ready (inv.ready),
    .inv_item  (inv.payload)
);

// ===== sim/tb_matrix4_inverse_determinant_unit.sv =====
// ----------------------------------------------------------------------------
// tb_matrix4_inverse_determinant_unit: regression for the 4x4 matrix inverse
// Streams matrices one row per transfer with random gaps and output stalls,
// predicts the four inverse rows and the determinant with exact wide integer
// arithmetic, and compares every result row field by field in order.
// ----------------------------------------------------------------------------
module tb_matrix4_inverse_determinant_unit;
    import m4i_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;

    // inverse calculator and store of pending inverse rows
    class inverse_scoreboard;
        elem_t     rows_held[16];
        int        slot;
        inv_item_t pending_rows[$];
        int        mismatches;
        int        matrices;
        int        singular_seen;
        int        rows_checked;

        function void clear();
            slot = 0;
            mismatches = 0;
            matrices = 0;
            singular_seen = 0;
            rows_checked = 0;
            pending_rows.delete();
        endfunction

        // saturate a signed 128-bit value to Q16.16 range
        function fix_t clamp32(logic signed [127:0] v);
            if (v > 128'sd2147483647)
                return 32'h7fffffff;
            if (v < -128'sd2147483648)
                return 32'h80000000;
            return fix_t'(v[31:0]);
        endfunction

        // note an accepted row, build expected rows once a matrix is complete
        function void note_row(row_item_t it);
            logic signed [63:0]  m[4][4];
            logic signed [63:0]  s[6];
            logic signed [63:0]  c[6];
            logic signed [63:0]  cof[4][4];
            logic signed [127:0] det;
            logic signed [127:0] num;
            logic signed [127:0] quo;
            logic signed [127:0] amag;
            logic signed [127:0] dmag;
            inv_item_t           o;
            rows_held[slot*4+0] = it.elem_c0;
            rows_held[slot*4+1] = it.elem_c1;
            rows_held[slot*4+2] = it.elem_c2;
            rows_held[slot*4+3] = it.elem_c3;
            if (slot != 3)
            begin
                slot++;
                return;
            end
            slot = 0;
            matrices++;
            for (int r = 0; r < 4; r++)
                for (int k = 0; k < 4; k++)
                    m[r][k] = 64'(rows_held[r*4+k]);
            s[0] = m[0][0]*m[1][1] - m[1][0]*m[0][1];
            s[1] = m[0][0]*m[1][2] - m[1][0]*m[0][2];
            s[2] = m[0][0]*m[1][3] - m[1][0]*m[0][3];
            s[3] = m[0][1]*m[1][2] - m[1][1]*m[0][2];
            s[4] = m[0][1]*m[1][3] - m[1][1]*m[0][3];
            s[5] = m[0][2]*m[1][3] - m[1][2]*m[0][3];
            c[5] = m[2][2]*m[3][3] - m[3][2]*m[2][3];
            c[4] = m[2][1]*m[3][3] - m[3][1]*m[2][3];
            c[3] = m[2][1]*m[3][2] - m[3][1]*m[2][2];
            c[2] = m[2][0]*m[3][3] - m[3][0]*m[2][3];
            c[1] = m[2][0]*m[3][2] - m[3][0]*m[2][2];
            c[0] = m[2][0]*m[3][1] - m[3][0]*m[2][1];
            det = 128'(s[0])*128'(c[5]) - 128'(s[1])*128'(c[4])
                + 128'(s[2])*128'(c[3]) + 128'(s[3])*128'(c[2])
                - 128'(s[4])*128'(c[1]) + 128'(s[5])*128'(c[0]);
            cof[0][0] =  m[1][1]*c[5] - m[1][2]*c[4] + m[1][3]*c[3];
            cof[0][1] = -m[0][1]*c[5] + m[0][2]*c[4] - m[0][3]*c[3];
            cof[0][2] =  m[3][1]*s[5] - m[3][2]*s[4] + m[3][3]*s[3];
            cof[0][3] = -m[2][1]*s[5] + m[2][2]*s[4] - m[2][3]*s[3];
            cof[1][0] = -m[1][0]*c[5] + m[1][2]*c[2] - m[1][3]*c[1];
            cof[1][1] =  m[0][0]*c[5] - m[0][2]*c[2] + m[0][3]*c[1];
            cof[1][2] = -m[3][0]*s[5] + m[3][2]*s[2] - m[3][3]*s[1];
            cof[1][3] =  m[2][0]*s[5] - m[2][2]*s[2] + m[2][3]*s[1];
            cof[2][0] =  m[1][0]*c[4] - m[1][1]*c[2] + m[1][3]*c[0];
            cof[2][1] = -m[0][0]*c[4] + m[0][1]*c[2] - m[0][3]*c[0];
            cof[2][2] =  m[3][0]*s[4] - m[3][1]*s[2] + m[3][3]*s[0];
            cof[2][3] = -m[2][0]*s[4] + m[2][1]*s[2] - m[2][3]*s[0];
            cof[3][0] = -m[1][0]*c[3] + m[1][1]*c[1] - m[1][2]*c[0];
            cof[3][1] =  m[0][0]*c[3] - m[0][1]*c[1] + m[0][2]*c[0];
            cof[3][2] = -m[3][0]*s[3] + m[3][1]*s[1] - m[3][2]*s[0];
            cof[3][3] =  m[2][0]*s[3] - m[2][1]*s[1] + m[2][2]*s[0];
            if (det == 0)
                singular_seen++;
            dmag = (det < 0) ? -det : det;
            for (int r = 0; r < 4; r++)
            begin
                fix_t e[4];
                for (int k = 0; k < 4; k++)
                begin
                    e[k] = '0;
                    if (det != 0)
                    begin
                        num = 128'(cof[r][k]);
                        amag = (num < 0) ? -num : num;
                        // truncating divide on magnitudes, sign applied after
                        quo = (amag <<< 24) / dmag;
                        if ((num < 0) != (det < 0))
                            quo = -quo;
                        e[k] = clamp32(quo);
                    end
                end
                o.inv_c0 = e[0];
                o.inv_c1 = e[1];
                o.inv_c2 = e[2];
                o.inv_c3 = e[3];
                o.out_row = 2'(r);
                o.last_row = (r == 3);
                o.singular = (det == 0);
                o.det_value = (det == 0) ? '0 : clamp32(det >>> 16);
                pending_rows.push_back(o);
            end
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            mismatches++;
        endfunction

        // compare one transferred inverse row with the oldest expectation
        function void check_row(inv_item_t got);
            inv_item_t want;
            if (pending_rows.size() == 0)
            begin
                report("unexpected row", 32'(got.out_row), 0);
                return;
            end
            want = pending_rows.pop_front();
            rows_checked++;
            if (got.inv_c0 !== want.inv_c0) report("inv_c0", got.inv_c0, want.inv_c0);
            if (got.inv_c1 !== want.inv_c1) report("inv_c1", got.inv_c1, want.inv_c1);
            if (got.inv_c2 !== want.inv_c2) report("inv_c2", got.inv_c2, want.inv_c2);
            if (got.inv_c3 !== want.inv_c3) report("inv_c3", got.inv_c3, want.inv_c3);
            if (got.out_row !== want.out_row)
                report("out_row", 32'(got.out_row), 32'(want.out_row));
            if (got.last_row !== want.last_row)
                report("last_row", 32'(got.last_row), 32'(want.last_row));
            if (got.singular !== want.singular)
                report("singular", 32'(got.singular), 32'(want.singular));
            if (got.det_value !== want.det_value)
                report("det_value", got.det_value, want.det_value);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycles;

    m4i_stream_if #(.payload_t(row_item_t)) mat ();
    m4i_stream_if #(.payload_t(inv_item_t)) inv ();

    inverse_scoreboard board;

    matrix4_inverse_determinant_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .mat   (mat.sink),
        .inv   (inv.source)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle count and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: sample at rising edge, random stall on ready
    initial
    begin
        int stall;
        inv.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall != 0)
            begin
                inv.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            inv.ready <= 1'b1;
            @(posedge clk);
            while (!inv.valid)
                @(posedge clk);
            board.check_row(inv.payload);
            @(negedge clk);
        end
    end

    // draw a random element, weighted toward the extremes and small values
    function automatic elem_t pick_elem();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return elem_t'($urandom_range(0, 512)) - 16'sd256;
            3: return 16'sd0;
            default: return elem_t'($urandom);
        endcase
    endfunction

    // send one row with a random gap first, valid stays up until the next gap
    task automatic send_row(input elem_t a, input elem_t b, input elem_t c, input elem_t d);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            mat.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        mat.payload <= '{elem_c0: a, elem_c1: b, elem_c2: c, elem_c3: d};
        mat.valid <= 1'b1;
        @(posedge clk);
        while (!mat.ready)
            @(posedge clk);
        board.note_row(mat.payload);
        @(negedge clk);
    endtask

    // a scaled identity matrix with v on the diagonal
    task automatic send_diag(input elem_t v);
        send_row(v, '0, '0, '0);
        send_row('0, v, '0, '0);
        send_row('0, '0, v, '0);
        send_row('0, '0, '0, v);
    endtask

    initial
    begin
        elem_t v;
        board = new();
        board.clear();
        mat.valid = 1'b0;
        mat.payload = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity, tiny diagonal (large inverse), huge diagonal
        send_diag(16'sd256);
        send_diag(16'sd1);
        send_diag(16'sh7fff);
        // singular: two equal rows
        send_row(16'sh7fff, 16'sh8000, 16'sd5, -16'sd3);
        send_row(16'sh7fff, 16'sh8000, 16'sd5, -16'sd3);
        send_row(16'sd1, 16'sd2, 16'sd3, 16'sd4);
        send_row(-16'sd1, 16'sd7, 16'sd0, 16'sh8000);
        // negative determinant, all-minimum diagonal
        send_diag(16'sh8000);
        send_row(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_row(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_row(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff);

        // random matrices, some made singular by a zero row
        for (int n = 0; n < 60; n++)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    v = pick_elem();
                    send_diag(v);
                end
                1:
                begin
                    send_row('0, '0, '0, '0);
                    for (int r = 0; r < 3; r++)
                        send_row(pick_elem(), pick_elem(), pick_elem(), pick_elem());
                end
                default:
                    for (int r = 0; r < 4; r++)
                        send_row(pick_elem(), pick_elem(), pick_elem(), pick_elem());
            endcase
        end
        mat.valid <= 1'b0;

        while (board.pending_rows.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        $display("%0d matrices, %0d singular, %0d inverse rows checked",
                 board.matrices, board.singular_seen, board.rows_checked);
        if (board.mismatches == 0 && board.pending_rows.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
